>>> rtl/assert_macros.svh
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/bsr_pkg.sv
package bsr_pkg;

    localparam int WINDOW      = 64;
    localparam int STORE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int WIN_W       = $clog2(WINDOW + 1);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_MARKER = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] stream_index;
        logic [7:0]  data_byte;
        logic        is_final;
        logic [15:0] space_available;
    } in_item_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic        stream_closed;
        logic [6:0]  pending_count;
    } out_item_t;

    typedef struct packed {
        logic             is_marker;
        logic [63:0]      stream_index;
        logic [7:0]       data_byte;
        logic             is_final;
        logic [WIN_W-1:0] win;
        logic [15:0]      space;
    } work_item_t;

endpackage

>>> rtl/bsr_front.sv
module bsr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  bsr_pkg::in_item_t   item,
    output logic                work_valid,
    output bsr_pkg::work_item_t work,
    input  logic                work_pop
);
    import bsr_pkg::*;

    work_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QFILL_W-1:0]   fill_reg;
    logic [QFILL_W-1:0]   fill_next;
    work_item_t           classified;
    logic                 push;
    logic                 pop;

    // acceptance window is the smaller of downstream space and the store window
    always_comb
    begin
        classified.is_marker    = (item.operation == OP_MARKER);
        classified.stream_index = item.stream_index;
        classified.data_byte    = item.data_byte;
        classified.is_final     = item.is_final;
        classified.space        = item.space_available;
        if (item.space_available < 16'(WINDOW))
        begin
            classified.win = item.space_available[WIN_W-1:0];
        end
        else
        begin
            classified.win = WIN_W'(WINDOW);
        end
    end

    assign item_stall = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign work_valid = (fill_reg != '0);
    assign work       = entry_reg[rd_ptr_reg];
    assign push       = item_valid && !item_stall;
    assign pop        = work_pop && work_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

>>> rtl/bsr_back.sv
module bsr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                work_valid,
    input  bsr_pkg::work_item_t work,
    output logic                work_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output bsr_pkg::out_item_t  result
);
    import bsr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [7:0]             mem [STORE_DEPTH];
    logic [7:0]             rd_data_reg;
    logic                   mem_we;
    logic [STORE_DEPTH-1:0] held_valid_reg;
    logic [STORE_DEPTH-1:0] held_valid_next;
    logic [63:0]            next_exp_reg;
    logic [63:0]            next_exp_next;
    logic [CNT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       total_next;
    logic                   end_known_reg;
    logic                   end_known_next;
    logic [63:0]            end_pos_reg;
    logic [63:0]            end_pos_next;
    logic                   closed_reg;
    logic                   closed_next;
    logic [15:0]            space_reg;
    logic [15:0]            space_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    logic [7:0]             hold_byte_reg;
    logic [7:0]             hold_byte_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    out_item_t              result_reg;
    out_item_t              result_next;

    logic [SLOT_W-1:0]      slot_in;
    logic [SLOT_W-1:0]      slot_nx;
    logic [63:0]            offset;
    logic                   in_window;
    logic                   closed_now;
    logic                   out_free;
    logic                   cont;

    assign slot_in    = work.stream_index[SLOT_W-1:0];
    assign slot_nx    = next_exp_reg[SLOT_W-1:0];
    assign offset     = work.stream_index - next_exp_reg;
    assign in_window  = (offset[63:WIN_W] == '0) && (offset[WIN_W-1:0] < work.win);
    assign closed_now = closed_reg || (end_known_reg && (next_exp_reg == end_pos_reg));
    assign out_free   = !result_valid_reg || !result_stall;
    assign cont       = !closed_now && (space_reg != '0)
                        && (count_reg != CNT_W'(STORE_DEPTH)) && held_valid_reg[slot_nx];

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        held_valid_next   = held_valid_reg;
        next_exp_next     = next_exp_reg;
        total_next        = total_reg;
        end_known_next    = end_known_reg;
        end_pos_next      = end_pos_reg;
        closed_next       = closed_reg;
        space_next        = space_reg;
        count_next        = count_reg;
        hold_valid_next   = hold_valid_reg;
        hold_byte_next    = hold_byte_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        mem_we            = 1'b0;
        work_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (work_valid)
                begin
                    work_pop   = 1'b1;
                    space_next = work.space;
                    count_next = '0;
                    state_next = ST_CHECK;
                    if (!closed_reg)
                    begin
                        if (work.is_marker)
                        begin
                            end_known_next = 1'b1;
                            end_pos_next   = work.stream_index;
                        end
                        else
                        begin
                            // a trimmed final byte still moves the end index
                            if (work.is_final)
                            begin
                                end_known_next = 1'b1;
                                end_pos_next   = work.stream_index + 64'd1;
                            end
                            if (in_window && !held_valid_reg[slot_in])
                            begin
                                held_valid_next[slot_in] = 1'b1;
                                mem_we                   = 1'b1;
                                total_next               = total_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                closed_next = closed_now;
                // a delivered byte waits here until we know if it ends the run
                if (cont && !hold_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (out_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.has_byte      = hold_valid_reg;
                    result_next.out_byte      = hold_valid_reg ? hold_byte_reg : 8'd0;
                    result_next.last_of_run   = !cont;
                    result_next.stream_closed = closed_now;
                    result_next.pending_count = 7'(total_reg);
                    hold_valid_next           = 1'b0;
                    state_next                = cont ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                hold_byte_next           = rd_data_reg;
                hold_valid_next          = 1'b1;
                held_valid_next[slot_nx] = 1'b0;
                total_next               = total_reg - 1'b1;
                next_exp_next            = next_exp_reg + 64'd1;
                space_next               = space_reg - 16'd1;
                count_next               = count_reg + 1'b1;
                state_next               = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            held_valid_reg   <= '0;
            next_exp_reg     <= '0;
            total_reg        <= '0;
            end_known_reg    <= 1'b0;
            end_pos_reg      <= '0;
            closed_reg       <= 1'b0;
            space_reg        <= '0;
            count_reg        <= '0;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            held_valid_reg   <= held_valid_next;
            next_exp_reg     <= next_exp_next;
            total_reg        <= total_next;
            end_known_reg    <= end_known_next;
            end_pos_reg      <= end_pos_next;
            closed_reg       <= closed_next;
            space_reg        <= space_next;
            count_reg        <= count_next;
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
        result_reg    <= result_next;
    end

    // byte store, read address follows the next expected slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_in] <= work.data_byte;
        end
        rd_data_reg <= mem[slot_nx];
    end

endmodule

>>> rtl/byte_stream_reassembler.sv
// an accepted item waits in the front queue until the back end, in its idle state, pops it;
//   the result beat is registered from the check state, and each delivered byte passes the emit
//   state and then the check state again; the back end takes a new item only when back in idle,
//   so its pace is set by the check/emit loop around the registered byte store read
// a 2-entry queue lets the front accept while the back end drains
// reset (rst_n, async, active low) clears all valid marks and control state at once;
//   store contents are not cleared and need no clearing pass
module byte_stream_reassembler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  bsr_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output bsr_pkg::out_item_t result
);
    import bsr_pkg::*;

    logic       work_valid;
    logic       work_pop;
    work_item_t work;

    bsr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .work_valid (work_valid),
        .work       (work),
        .work_pop   (work_pop)
    );

    bsr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .work_valid   (work_valid),
        .work         (work),
        .work_pop     (work_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> rtl/bsr_checker.sv
`include "assert_macros.svh"

module bsr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input bsr_pkg::out_item_t result
);
    import bsr_pkg::*;

    // a beat without a byte is always the only and last one of its run
    `ASSERT_IMPLY(a_empty_is_last, clk, rst_n, result_valid && !result.has_byte, result.last_of_run)
    `ASSERT_IMPLY(a_empty_zero_byte, clk, rst_n, result_valid && !result.has_byte, result.out_byte == 8'd0)
    `ASSERT_IMPLY(a_pending_range, clk, rst_n, result_valid, result.pending_count <= 7'(STORE_DEPTH))
    // once closed, the stream stays closed
    `ASSERT_NEXT(a_closed_sticky, clk, rst_n, result_valid && !result_stall && result.stream_closed, !result_valid || result.stream_closed)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind byte_stream_reassembler bsr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bsr_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int REPORT_MAX   = 10;
    localparam int STREAM_ITEMS = 130;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    // mirror of the reassembly state
    logic [7:0]  held_data [STORE_DEPTH];
    bit          held_mark [STORE_DEPTH];
    logic [63:0] next_idx = '0;
    int          held_cnt = 0;
    bit          end_seen = 1'b0;
    logic [63:0] end_idx = '0;
    bit          closed = 1'b0;

    out_item_t   deliveries [$];
    int          failures = 0;
    int          cycles = 0;
    int          stall_left = 0;
    int          stream_items = 0;
    bit          calm = 1'b0;

    byte_stream_reassembler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] draw_room();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'hffff;
        if (r < 12)
            return 16'($urandom_range(0, 8));
        if (r < 20)
            return 16'($urandom_range(9, 63));
        return 16'($urandom_range(64, 65535));
    endfunction

    function automatic logic [63:0] far_end();
        return next_idx + 64'd100000 + 64'($urandom);
    endfunction

    function automatic in_item_t mk_data(logic [63:0] idx, logic [7:0] b, logic fin,
                                         logic [15:0] room);
        in_item_t x;
        x.operation       = OP_DATA;
        x.stream_index    = idx;
        x.data_byte       = b;
        x.is_final        = fin;
        x.space_available = room;
        return x;
    endfunction

    function automatic in_item_t mk_marker(logic [63:0] idx, logic [15:0] room);
        in_item_t x;
        x.operation       = OP_MARKER;
        x.stream_index    = idx;
        x.data_byte       = 8'($urandom);
        x.is_final        = 1'($urandom);
        x.space_available = room;
        return x;
    endfunction

    function automatic void check_end();
        if (end_seen && next_idx == end_idx)
            closed = 1'b1;
    endfunction

    function automatic out_item_t status_beat(logic has, logic [7:0] b);
        out_item_t r;
        r.has_byte      = has;
        r.out_byte      = b;
        r.last_of_run   = 1'b0;
        r.stream_closed = closed;
        r.pending_count = 7'(held_cnt);
        return r;
    endfunction

    // apply one accepted beat to the mirror and queue the beats it delivers
    function automatic void reassemble(in_item_t x);
        logic [63:0]       off;
        logic [63:0]       win;
        int                room;
        int                n;
        logic [SLOT_W-1:0] slot;
        out_item_t         r;
        room = int'(x.space_available);
        n = 0;
        if (!closed)
        begin
            win = (room < WINDOW) ? 64'(room) : 64'(WINDOW);
            if (x.operation == OP_MARKER)
            begin
                end_seen = 1'b1;
                end_idx = x.stream_index;
            end
            else
            begin
                off = x.stream_index - next_idx;
                // the end moves even when the final byte itself falls outside the window
                if (x.is_final)
                begin
                    end_seen = 1'b1;
                    end_idx = x.stream_index + 64'd1;
                end
                slot = x.stream_index[SLOT_W-1:0];
                if (off < win && !held_mark[slot])
                begin
                    held_mark[slot] = 1'b1;
                    held_data[slot] = x.data_byte;
                    held_cnt++;
                end
            end
            check_end();
            while (!closed && room > 0 && n < STORE_DEPTH && held_mark[next_idx[SLOT_W-1:0]])
            begin
                slot = next_idx[SLOT_W-1:0];
                held_mark[slot] = 1'b0;
                held_cnt--;
                next_idx = next_idx + 64'd1;
                room--;
                check_end();
                deliveries.push_back(status_beat(1'b1, held_data[slot]));
                n++;
            end
        end
        if (n == 0)
            deliveries.push_back(status_beat(1'b0, 8'h00));
        r = deliveries.pop_back();
        r.last_of_run = 1'b1;
        deliveries.push_back(r);
    endfunction

    function automatic string describe(out_item_t r);
        return $sformatf("has_byte=%0d out_byte=%02h last=%0d closed=%0d pending=%0d",
                         r.has_byte, r.out_byte, r.last_of_run, r.stream_closed,
                         r.pending_count);
    endfunction

    function automatic void flag_failure(string msg);
        failures++;
        if (failures <= REPORT_MAX)
            $display("cycle %0d: %s", cycles, msg);
    endfunction

    task automatic send_item(input in_item_t x);
        int gap;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= x;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        reassemble(x);
    endtask

    // keep a reachable end index out of the way until the closing test
    task automatic keep_end_clear();
        if (end_seen && !closed && (end_idx - next_idx) < 64'd4096)
            send_item(mk_marker(far_end(), draw_room()));
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0:
            begin
                send_item(mk_data(next_idx - 64'($urandom_range(2, 300)), 8'($urandom),
                                  1'($urandom), draw_room()));
            end
            1:
            begin
                send_item(mk_data({$urandom, $urandom}, 8'($urandom), 1'($urandom),
                                  draw_room()));
            end
            2:
            begin
                send_item(mk_marker(far_end(), draw_room()));
            end
            3:
            begin
                send_item(mk_marker(next_idx - 64'($urandom_range(1, 1000)), draw_room()));
            end
            default:
            begin
                // final byte trimmed by the window
                send_item(mk_data(next_idx + 64'($urandom_range(64, 300)), 8'($urandom),
                                  1'b1, 16'hffff));
            end
        endcase
    endtask

    task automatic send_segment(int len, bit noisy, bit hold);
        logic [63:0] base;
        int          order [64];
        int          span;
        int          k;
        int          j;
        int          t;
        base = next_idx;
        for (k = 0; k < len; k++)
            order[k] = hold ? (k + 1) % len : k;
        // with hold set the head byte comes last and the whole run drains at once
        span = hold ? len - 1 : len;
        for (k = span - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (k = 0; k < len; k++)
        begin
            if (noisy && $urandom_range(0, 5) == 0)
            begin
                send_noise();
                keep_end_clear();
            end
            send_item(mk_data(base + 64'(order[k]), 8'($urandom), 1'b0, draw_room()));
            stream_items++;
            keep_end_clear();
        end
    endtask

    task automatic test_empty_window();
        send_item(mk_data(64'd0, 8'hff, 1'b0, 16'd0));
        send_item(mk_data(64'd0, 8'h00, 1'b0, 16'd1));
    endtask

    task automatic test_reorder_duplicate();
        logic [63:0] base;
        base = next_idx;
        send_item(mk_data(base + 64'd2, 8'h5a, 1'b0, 16'hffff));
        send_item(mk_data(base + 64'd1, 8'ha5, 1'b0, 16'hffff));
        send_item(mk_data(base + 64'd1, 8'h3c, 1'b0, 16'hffff));
        send_item(mk_data(base, 8'hc3, 1'b0, 16'hffff));
    endtask

    task automatic test_window_edges();
        logic [63:0] base;
        base = next_idx;
        send_item(mk_data(base + 64'd8, 8'h18, 1'b0, 16'd8));
        send_item(mk_data(base + 64'd7, 8'h17, 1'b0, 16'd8));
        send_item(mk_data(base + 64'd64, 8'h64, 1'b0, 16'hffff));
        send_item(mk_data(base + 64'd63, 8'h63, 1'b0, 16'hffff));
    endtask

    task automatic test_partial_drain();
        logic [63:0] base;
        base = next_idx;
        send_item(mk_data(base + 64'd2, 8'h02, 1'b0, 16'hffff));
        send_item(mk_data(base + 64'd1, 8'h01, 1'b0, 16'hffff));
        send_item(mk_data(base, 8'h00, 1'b0, 16'd2));
        send_item(mk_data(base - 64'd1, 8'hee, 1'b0, 16'd0));
        send_item(mk_data(base - 64'd1, 8'hdd, 1'b0, 16'd1));
    endtask

    task automatic test_late_and_far();
        send_item(mk_data(64'd0, 8'h99, 1'b0, 16'hffff));
        send_item(mk_data(64'hffff_ffff_ffff_ffff, 8'h88, 1'b0, 16'hffff));
        send_item(mk_data(next_idx - 64'd1, 8'h77, 1'b0, 16'hffff));
    endtask

    task automatic test_end_reports();
        send_item(mk_marker(64'hffff_ffff_ffff_ffff, 16'hffff));
        send_item(mk_marker(64'd0, 16'hffff));
        send_item(mk_data(next_idx + 64'd70, 8'h70, 1'b1, 16'hffff));
        send_item(mk_data(next_idx - 64'd2, 8'h66, 1'b1, 16'hffff));
        send_item(mk_marker(far_end(), 16'hffff));
    endtask

    task automatic test_random_stream();
        int len;
        send_segment(STORE_DEPTH, 1'b0, 1'b1);
        while (stream_items < STREAM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            send_segment(len, $urandom_range(0, 2) != 0, len > 16 && $urandom_range(0, 1) == 1);
        end
        calm = 1'b0;
    endtask

    task automatic test_closed_stream();
        logic [63:0] base;
        base = next_idx;
        send_item(mk_data(base + 64'd2, 8'hff, 1'b1, 16'hffff));
        send_item(mk_data(base + 64'd1, 8'h00, 1'b0, 16'hffff));
        send_item(mk_data(base, 8'h81, 1'b0, 16'hffff));
        // everything after the close only reports state
        send_item(mk_data(base + 64'd3, 8'h42, 1'b0, 16'hffff));
        send_item(mk_marker(base + 64'd100, 16'hffff));
        send_item(mk_data(base + 64'd3, 8'h24, 1'b1, 16'd0));
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (!calm && $urandom_range(0, 2) == 0)
                stall_left <= idle_len();
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (deliveries.size() == 0)
            begin
                flag_failure({"unexpected beat: ", describe(result)});
            end
            else
            begin
                want = deliveries.pop_front();
                if (result.has_byte !== want.has_byte || result.out_byte !== want.out_byte
                    || result.last_of_run !== want.last_of_run
                    || result.stream_closed !== want.stream_closed
                    || result.pending_count !== want.pending_count)
                    flag_failure({"mismatch: expected ", describe(want), " got ",
                                  describe(result)});
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("byte_stream_reassembler regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_window();
        test_reorder_duplicate();
        test_window_edges();
        test_partial_drain();
        test_late_and_far();
        test_end_reports();
        test_random_stream();
        test_closed_stream();

        @(negedge clk);
        item_valid <= 1'b0;
        while (deliveries.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (deliveries.size() > 0)
            flag_failure($sformatf("%0d beats never arrived", deliveries.size()));

        if (failures == 0)
            $display("byte_stream_reassembler regression: pass");
        else
            $display("byte_stream_reassembler regression: fail");
        $finish;
    end

endmodule
